// ===== hdl/fat12_cluster_chain_walker_defines.svh =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fccw_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker package
// Sizes, codes and state types shared by the walker modules.
// ----------------------------------------------------------------------------
package fccw_pkg;

    localparam int FAT_BYTES  = 512;
    localparam int MAX_CHAIN  = 64;
    localparam int FAT_AW     = $clog2(FAT_BYTES);
    localparam int BANK_DEPTH = FAT_BYTES / 2;
    localparam int BANK_AW    = FAT_AW - 1;
    // Wide enough for cluster + cluster/2 + 1 and for FAT_BYTES itself.
    localparam int CL_AW      = 14;
    localparam int STEP_W     = $clog2(MAX_CHAIN + 1);
    localparam int GEOM_W     = 21;

    localparam logic [11:0] END_MARK   = 12'hFF8;
    localparam logic [11:0] FIRST_DATA = 12'd2;

    localparam logic [1:0] CFG_DATA_START  = 2'd0;
    localparam logic [1:0] CFG_SECT_PER_CL = 2'd1;
    localparam logic [1:0] CFG_BYTES_SECT  = 2'd2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_WALK  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic               start;
        logic [11:0]        cluster;
        logic [31:0]        data_start;
        logic [7:0]         sect_per_cl;
        logic [12:0]        bytes_sect;
    } t_offset_req;

endpackage

// ===== hdl/fccw_ram.sv =====
// ----------------------------------------------------------------------------
// FAT byte bank
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fccw_offset.sv =====
// ----------------------------------------------------------------------------
// Cluster data offset unit
// Computes data_start + (cluster - 2) * sectors * bytes, modulo 2**32.
// ----------------------------------------------------------------------------
module fccw_offset import fccw_pkg::*; (
    input  logic        i_clk,
    input  t_offset_req i_req,
    output logic [31:0] o_offset
);

    logic [GEOM_W-1:0] r_geom;
    logic [31:0]       r_prod;
    logic [11:0]       rel;
    logic [32:0]       prod_full;

    // Cluster size in bytes, refreshed every cycle from the live registers.
    always_ff @(posedge i_clk) begin
        r_geom <= GEOM_W'(i_req.sect_per_cl) * GEOM_W'(i_req.bytes_sect);
    end

    assign rel       = i_req.cluster - FIRST_DATA;
    assign prod_full = 33'(rel) * 33'(r_geom);

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= prod_full[31:0];
        end
    end

    assign o_offset = i_req.data_start + r_prod;

endmodule

// ===== hdl/fat12_cluster_chain_walker.sv =====
// A FAT write is accepted in the idle state. The first result of a walk
// passes through the ISSUE and EVAL states into the result register.
// Each cluster takes a FAT bank read in ISSUE, then the entry decode and
// offset add in EVAL, which waits on a full result register; requests wait for idle.
// Reset clears the control state and the configuration registers; the FAT
// store is not cleared and reads back undefined until written.
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Holds the FAT in two byte banks and follows cluster chains through it.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_defines.svh"

module fat12_cluster_chain_walker import fccw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] fat_address, [16:9] fat_byte, [28:17] start_cluster, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cluster, [43:12] byte_offset, [47:44] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    t_state       r_state, n_state;
    logic [11:0]  r_cur, n_cur;
    logic [STEP_W-1:0] r_steps, n_steps;

    logic [31:0]  r_data_start;
    logic [7:0]   r_sect_per_cl;
    logic [12:0]  r_bytes_sect;

    logic         r_bad_low, r_bad_range, r_apar;

    logic         r_m_valid;
    logic [11:0]  r_m_cluster;
    logic [31:0]  r_m_offset;
    logic         r_m_last;
    t_status      r_m_status;

    logic         s_accept;
    logic         issue;
    logic         load;
    logic         n_last;
    t_status      n_status;
    logic [31:0]  n_offset;

    logic [CL_AW-1:0] wa, ra, ra1;
    logic         wr_ok;
    logic [7:0]   even_q, odd_q;
    logic [15:0]  pair;
    logic [11:0]  next_cl;
    logic         slot_free;
    logic [31:0]  offset;
    t_offset_req  off_req;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start  <= '0;
            r_sect_per_cl <= 8'd1;
            r_bytes_sect  <= 13'd512;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DATA_START:  r_data_start  <= i_cfg_wdata;
                CFG_SECT_PER_CL: r_sect_per_cl <= i_cfg_wdata[7:0];
                CFG_BYTES_SECT:  r_bytes_sect  <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // FAT store: even bytes in one bank, odd bytes in the other, so that
    // both bytes of an entry pair come out in one read.
    // ------------------------------------------------------------------
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign wa       = CL_AW'(s_axis_tdata[8:0]);
    assign wr_ok    = s_accept && (t_opcode'(s_axis_tuser) == OP_WRITE)
                      && (wa < CL_AW'(FAT_BYTES));

    assign ra  = CL_AW'(r_cur) + CL_AW'(r_cur[11:1]);
    assign ra1 = ra + CL_AW'(1);

    fccw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_even (
        .i_clk   (i_clk),
        .i_we    (wr_ok && !wa[0]),
        .i_waddr (wa[FAT_AW-1:1]),
        .i_wdata (s_axis_tdata[16:9]),
        .i_re    (issue),
        .i_raddr (ra1[FAT_AW-1:1]),
        .o_rdata (even_q)
    );

    fccw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_odd (
        .i_clk   (i_clk),
        .i_we    (wr_ok && wa[0]),
        .i_waddr (wa[FAT_AW-1:1]),
        .i_wdata (s_axis_tdata[16:9]),
        .i_re    (issue),
        .i_raddr (ra[FAT_AW-1:1]),
        .o_rdata (odd_q)
    );

    // ------------------------------------------------------------------
    // Offset unit: product registered in the issue cycle, add in eval.
    // ------------------------------------------------------------------
    assign off_req.start       = issue;
    assign off_req.cluster     = r_cur;
    assign off_req.data_start  = r_data_start;
    assign off_req.sect_per_cl = r_sect_per_cl;
    assign off_req.bytes_sect  = r_bytes_sect;

    fccw_offset u_offset (
        .i_clk    (i_clk),
        .i_req    (off_req),
        .o_offset (offset)
    );

    // ------------------------------------------------------------------
    // Entry decode
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_bad_low   <= (r_cur < FIRST_DATA);
            r_bad_range <= (ra1 >= CL_AW'(FAT_BYTES));
            r_apar      <= ra[0];
        end
    end

    // An odd pair address starts in the odd bank, so the banks swap roles.
    assign pair      = r_apar ? {even_q, odd_q} : {odd_q, even_q};
    assign next_cl   = r_cur[0] ? pair[15:4] : pair[11:0];
    assign slot_free = !r_m_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_steps <= n_steps;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cur         = r_cur;
        n_steps       = r_steps;
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        load          = 1'b0;
        n_last        = 1'b0;
        n_status      = ST_OK;
        n_offset      = offset;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (t_opcode'(s_axis_tuser) == OP_WALK)) begin
                    n_cur   = s_axis_tdata[28:17];
                    n_steps = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                // Only a start cluster can be an end mark here: an empty chain.
                if (r_cur >= END_MARK) begin
                    n_state = S_IDLE;
                end else begin
                    issue   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (r_bad_low) begin
                    n_last   = 1'b1;
                    n_status = ST_INVALID;
                    n_offset = '0;
                end else if (r_bad_range) begin
                    n_last   = 1'b1;
                    n_status = ST_INVALID;
                end else if (next_cl >= END_MARK) begin
                    n_last   = 1'b1;
                end else if (r_steps + STEP_W'(1) == STEP_W'(MAX_CHAIN)) begin
                    n_last   = 1'b1;
                    n_status = ST_TOO_LONG;
                end else begin
                    n_last   = 1'b0;
                end
                if (slot_free) begin
                    load = 1'b1;
                    if (n_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = next_cl;
                        n_steps = r_steps + STEP_W'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_cluster <= r_cur;
            r_m_offset  <= n_offset;
            r_m_last    <= n_last;
            r_m_status  <= n_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0, r_m_offset, r_m_cluster};
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_status;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FCCW_ASSERT_NEXT(a_last_ends_walk, i_clk, i_rst_n, load && n_last, r_state == S_IDLE, "walk continued after its final result")
    `FCCW_ASSERT_SAME(a_steps_bound, i_clk, i_rst_n, 1'b1, r_steps < STEP_W'(MAX_CHAIN), "step count ran past the chain limit")
    `FCCW_ASSERT_SAME(a_mid_chain_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == ST_OK, "non-final result carries an error status")
    `FCCW_ASSERT_SAME(a_eval_after_read, i_clk, i_rst_n, r_state == S_EVAL && $past(r_state) != S_EVAL, $past(r_state) == S_ISSUE, "entry decode without a bank read")

endmodule

// ===== verif/fat12_cluster_chain_walker_test.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker testbench
// Loads FAT entries and walks chains through them under several disk
// geometries. A shadow copy of the table and the geometry predicts every
// cluster the walker should visit. Each result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_test;
    import fccw_pkg::*;

    // Highest cluster whose FAT byte pair still lies inside the store.
    localparam int TOP_CLUSTER  = (2 * (FAT_BYTES - 2)) / 3;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int QUIET_CYCLES = 20;

    typedef struct {
        t_opcode     op;
        logic [8:0]  addr;
        logic [7:0]  data;
        logic [11:0] start;
    } t_fat_req;

    typedef struct {
        logic [11:0] cluster;
        logic [31:0] offset;
        logic        last;
        t_status     status;
    } t_visit;

    typedef enum {
        TAIL_END,
        TAIL_LOW,
        TAIL_OUTSIDE,
        TAIL_LOOP
    } t_tail;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_DATA_START;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // Shadow of the FAT and of the geometry registers.
    logic [7:0]  fat_img [FAT_BYTES];
    bit          fat_known [FAT_BYTES];
    logic [31:0] cfg_base = 32'd0;
    logic [7:0]  cfg_spc  = 8'd1;
    logic [12:0] cfg_bps  = 13'd512;

    t_fat_req    req_q [$];
    t_visit      visit_q [$];
    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int          gap_left       = 0;
    int          hold_left      = 0;
    bit          no_idle        = 1'b0;

    fat12_cluster_chain_walker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [31:0] cluster_offset(input logic [11:0] c);
        return cfg_base + (32'(c) - 32'd2) * 32'(cfg_spc) * 32'(cfg_bps);
    endfunction

    function automatic bit pair_in_store(input logic [11:0] c);
        return (int'(c) + int'(c >> 1) + 1) < FAT_BYTES;
    endfunction

    function automatic logic [11:0] fat_entry(input logic [11:0] c);
        int          a;
        logic [15:0] pair;
        a = int'(c) + int'(c >> 1);
        pair = {fat_img[a + 1], fat_img[a]};
        return c[0] ? pair[15:4] : pair[11:0];
    endfunction

    // Address of the first table byte a walk from start would read before it
    // has been loaded, or -1 if every byte on the way is known.
    function automatic int first_unwritten(input logic [11:0] start);
        logic [11:0] c;
        int          a;
        int          k;
        c = start;
        k = 0;
        while (c < END_MARK && k < MAX_CHAIN) begin
            if (c < FIRST_DATA || !pair_in_store(c))
                return -1;
            a = int'(c) + int'(c >> 1);
            if (!fat_known[a])
                return a;
            if (!fat_known[a + 1])
                return a + 1;
            if (fat_entry(c) >= END_MARK)
                return -1;
            c = fat_entry(c);
            k++;
        end
        return -1;
    endfunction

    task automatic predict_chain(input logic [11:0] start);
        logic [11:0] c;
        logic [11:0] nxt;
        logic [31:0] off;
        int          k;
        c = start;
        k = 0;
        while (c < END_MARK && k < MAX_CHAIN) begin
            if (c < FIRST_DATA) begin
                visit_q.push_back('{c, 32'd0, 1'b1, ST_INVALID});
                break;
            end
            off = cluster_offset(c);
            if (!pair_in_store(c)) begin
                visit_q.push_back('{c, off, 1'b1, ST_INVALID});
                break;
            end
            nxt = fat_entry(c);
            if (nxt >= END_MARK) begin
                visit_q.push_back('{c, off, 1'b1, ST_OK});
                break;
            end
            if (k + 1 == MAX_CHAIN) begin
                visit_q.push_back('{c, off, 1'b1, ST_TOO_LONG});
                break;
            end
            visit_q.push_back('{c, off, 1'b0, ST_OK});
            k++;
            c = nxt;
        end
    endtask

    task automatic queue_fat_write(input int a, input logic [7:0] b);
        fat_img[a] = b;
        fat_known[a] = 1'b1;
        req_q.push_back('{OP_WRITE, 9'(a), b, 12'($urandom_range(0, 4095))});
        queued_count++;
    endtask

    // Bytes that the walk would read unloaded are filled with noise first.
    task automatic queue_walk(input logic [11:0] start);
        int a;
        a = first_unwritten(start);
        while (a >= 0) begin
            queue_fat_write(a, 8'($urandom_range(0, 255)));
            a = first_unwritten(start);
        end
        predict_chain(start);
        req_q.push_back('{OP_WALK, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                          start});
        queued_count++;
    endtask

    // Read-modify-write of the byte pair keeps the neighbor entry's nibble.
    task automatic set_fat_entry(input logic [11:0] c, input logic [11:0] val);
        int          a;
        logic [15:0] pair;
        a = int'(c) + int'(c >> 1);
        pair[7:0]  = fat_known[a] ? fat_img[a] : 8'($urandom_range(0, 255));
        pair[15:8] = fat_known[a + 1] ? fat_img[a + 1] : 8'($urandom_range(0, 255));
        if (c[0])
            pair[15:4] = val;
        else
            pair[11:0] = val;
        queue_fat_write(a, pair[7:0]);
        queue_fat_write(a + 1, pair[15:8]);
    endtask

    task automatic build_chain(input int len, input t_tail tail);
        logic [11:0] hops [$];
        bit          taken [4096];
        logic [11:0] c;
        int          i;
        for (i = 0; i < len; i++) begin
            do c = 12'($urandom_range(2, TOP_CLUSTER)); while (taken[c]);
            taken[c] = 1'b1;
            hops.push_back(c);
        end
        for (i = 0; i + 1 < len; i++)
            set_fat_entry(hops[i], hops[i + 1]);
        case (tail)
            TAIL_END: begin
                set_fat_entry(hops[len - 1], 12'($urandom_range(12'hFF8, 12'hFFF)));
            end
            TAIL_LOW: begin
                set_fat_entry(hops[len - 1], 12'($urandom_range(0, 1)));
            end
            TAIL_OUTSIDE: begin
                set_fat_entry(hops[len - 1], 12'($urandom_range(TOP_CLUSTER + 1, 12'hFF7)));
            end
            default: begin
                set_fat_entry(hops[len - 1], hops[$urandom_range(0, len - 1)]);
            end
        endcase
        queue_walk(hops[0]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] base, input logic [7:0] spc,
                                input logic [12:0] bps);
        write_reg(CFG_DATA_START, base);
        write_reg(CFG_SECT_PER_CL, 32'(spc));
        write_reg(CFG_BYTES_SECT, 32'(bps));
        cfg_base = base;
        cfg_spc  = spc;
        cfg_bps  = bps;
    endtask

    // Waits until every request is taken and every visit has come back, then
    // lets a walk that produces nothing run out.
    task automatic wait_drained();
        while (req_q.size() != 0 || accepted_count != queued_count || visit_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_visit(input logic [47:0] tdata, input logic tlast,
                               input logic [1:0] tuser);
        t_visit v;
        if (visit_q.size() == 0) begin
            flag_error($sformatf("unexpected visit of cluster %0h", tdata[11:0]));
            return;
        end
        v = visit_q.pop_front();
        if (tdata[11:0] !== v.cluster)
            flag_error($sformatf("cluster %0h, expected %0h", tdata[11:0], v.cluster));
        if (tdata[43:12] !== v.offset)
            flag_error($sformatf("cluster %0h offset %0h, expected %0h",
                                 v.cluster, tdata[43:12], v.offset));
        if (tlast !== v.last)
            flag_error($sformatf("cluster %0h last %0b, expected %0b",
                                 v.cluster, tlast, v.last));
        if (tuser !== v.status)
            flag_error($sformatf("cluster %0h status %0d, expected %0d",
                                 v.cluster, tuser, v.status));
    endtask

    // Request driver: after each accepted request it sits out the gap drawn
    // when that request was loaded.
    always @(posedge i_clk) begin : feed_p
        t_fat_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                accepted_count <= accepted_count + 1;
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                s_axis_tdata  <= {3'b000, r.start, r.data, r.addr};
                s_axis_tuser  <= r.op;
                s_axis_tvalid <= 1'b1;
                gap_left      <= no_idle ? 0 : $urandom_range(0, 6);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : drain_p
        int wait_n;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            check_visit(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            wait_n = no_idle ? 0 : $urandom_range(0, 6);
            hold_left     <= wait_n;
            m_axis_tready <= (wait_n == 0);
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("fat12_cluster_chain_walker_test failed");
            $finish;
        end
    end

    initial begin : stim_p
        int          p;
        int unsigned goal;
        int          pick;
        int          len;
        int          tail_pick;
        t_tail       tail;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset geometry.
        queue_walk(12'h000);
        queue_walk(12'h001);
        queue_walk(12'hFF8);
        queue_walk(12'hFFF);
        queue_walk(12'(TOP_CLUSTER + 1));
        queue_walk(12'hFF7);
        set_fat_entry(12'd2, 12'hFFF);
        queue_walk(12'd2);
        set_fat_entry(12'd3, 12'd4);
        set_fat_entry(12'd4, 12'hFF8);
        queue_walk(12'd3);
        // A cluster that points at itself runs into the chain length limit.
        set_fat_entry(12'd5, 12'd5);
        queue_walk(12'd5);
        set_fat_entry(12'd6, 12'd1);
        queue_walk(12'd6);
        set_fat_entry(12'(TOP_CLUSTER), 12'hFF7);
        queue_walk(12'(TOP_CLUSTER));
        queue_fat_write(0, 8'hFF);
        queue_fat_write(1, 8'h00);
        wait_drained();

        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_geometry(32'd0, 8'd1, 13'd1);
                1: set_geometry(32'hFFFF_FFFF, 8'd128, 13'd4096);
                2: set_geometry($urandom, 8'($urandom_range(1, 128)),
                                13'($urandom_range(1, 4096)));
                3: set_geometry($urandom, 8'd0, 13'($urandom_range(1, 4096)));
                4: set_geometry($urandom, 8'd255, 13'd8191);
                default: set_geometry($urandom, 8'($urandom_range(1, 128)), 13'd0);
            endcase
            no_idle = (p == 2);
            goal = queued_count + 67;
            while (queued_count < goal) begin
                if ($urandom_range(0, 9) == 0)
                    no_idle = !no_idle;
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(62, 66)
                                                       : $urandom_range(1, 8);
                    tail_pick = $urandom_range(0, 9);
                    if (tail_pick < 6)
                        tail = TAIL_END;
                    else if (tail_pick == 6)
                        tail = TAIL_LOW;
                    else if (tail_pick == 7)
                        tail = TAIL_OUTSIDE;
                    else
                        tail = TAIL_LOOP;
                    build_chain(len, tail);
                end else if (pick < 72) begin
                    queue_walk(12'($urandom_range(0, 4095)));
                end else if (pick < 84) begin
                    queue_walk(12'($urandom_range(2, TOP_CLUSTER)));
                end else begin
                    queue_fat_write($urandom_range(0, FAT_BYTES - 1),
                                    8'($urandom_range(0, 255)));
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("fat12_cluster_chain_walker_test passed");
        else
            $display("fat12_cluster_chain_walker_test failed");
        $finish;
    end

endmodule
